@@ hdl/ftc_pkg.sv @@
package ftc_pkg;

	localparam int FRAME_INDEX_BITS = 24;

	localparam int REF_W     = 24;
	localparam int HRS_CFG_W = 7;
	localparam int MS_W      = 6;
	localparam int FPS_W     = 7;
	localparam int FRM_W     = 7;
	localparam int HOURS_W   = 16;
	localparam int SSEC_W    = 19;
	localparam int PROD_W    = SSEC_W + FPS_W;
	localparam int SUM_W     = ((PROD_W > FRAME_INDEX_BITS) ? PROD_W : FRAME_INDEX_BITS) + 2;
	localparam int Q_W       = SUM_W - 1;

	localparam int HQ_W     = Q_W - 11;
	localparam int DIVH_K   = Q_W + 12;
	localparam int DIVH_M_W = Q_W + 1;
	localparam int HPROD_W  = Q_W + DIVH_M_W;
	localparam int REM_W    = 12;
	localparam int DIVM_K   = REM_W + MS_W;
	localparam int DIVM_M_W = REM_W + 1;
	localparam int MPROD_W  = REM_W + DIVM_M_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [SSEC_W-1:0] SEC_PER_HOUR = SSEC_W'(3600);
	localparam logic [SSEC_W-1:0] SEC_PER_MIN  = SSEC_W'(60);
	localparam logic [FPS_W-1:0]  FPS_RESET    = FPS_W'(24);
	localparam logic [HOURS_W-1:0] HOURS_MAX   = '1;

	// rounded-up reciprocals: exact quotient for any dividend below 2^Q_W and 2^REM_W
	localparam logic [DIVH_M_W-1:0] DIVH_M = DIVH_M_W'(((longint'(1) << DIVH_K)
		+ longint'(SEC_PER_HOUR) - 1) / longint'(SEC_PER_HOUR));
	localparam logic [DIVM_M_W-1:0] DIVM_M = DIVM_M_W'(((longint'(1) << DIVM_K)
		+ longint'(SEC_PER_MIN) - 1) / longint'(SEC_PER_MIN));
	localparam logic [REM_W-1:0]    HOUR_LO = REM_W'(3600);
	localparam logic [MS_W-1:0]     MIN_LO  = MS_W'(60);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_HOURS   = 3'd0,
		REG_START_MINUTES = 3'd1,
		REG_START_SECONDS = 3'd2,
		REG_START_FRAMES  = 3'd3,
		REG_REFERENCE     = 3'd4,
		REG_FPS           = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [HRS_CFG_W-1:0] start_hours;
		logic [MS_W-1:0]      start_minutes;
		logic [MS_W-1:0]      start_seconds;
		logic [FRM_W-1:0]     start_frame_count;
		logic [REF_W-1:0]     reference_index;
		logic [FPS_W-1:0]     frames_per_second;
	} cfg_t;

	// classified word handed from front to back
	typedef struct packed {
		logic             unf;
		logic [FPS_W-1:0] fps;
		logic [Q_W-1:0]   tot;
	} item_t;

	typedef struct packed {
		logic [Q_W-1:0]   num;
		logic [FPS_W-1:0] rem;
		logic [FPS_W-1:0] fps;
		logic             unf;
	} fdiv_t;

	// one restoring step by the frame rate
	function automatic fdiv_t fdiv_step(input fdiv_t x);
		logic [FPS_W:0] sh;
		fdiv_t          y;
		sh = {x.rem, x.num[Q_W-1]};
		y  = x;
		if (sh >= {1'b0, x.fps}) begin
			y.rem = FPS_W'(sh - {1'b0, x.fps});
			y.num = {x.num[Q_W-2:0], 1'b1};
		end else begin
			y.rem = sh[FPS_W-1:0];
			y.num = {x.num[Q_W-2:0], 1'b0};
		end
		return y;
	endfunction

endpackage

@@ hdl/ftc_front.sv @@
module ftc_front (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  ftc_pkg::cfg_t                            cfg,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [ftc_pkg::FRAME_INDEX_BITS-1:0]     frame_index,
	input  logic                                     q_full,
	output logic                                     q_push,
	output ftc_pkg::item_t                           q_item
);

	logic                                     v_s1;
	logic                                     v_s2;
	logic                                     adv1;
	logic                                     adv2;
	logic [ftc_pkg::SSEC_W-1:0]               ssec_s1;
	logic [ftc_pkg::FPS_W-1:0]                fps_s1;
	logic [ftc_pkg::FRM_W-1:0]                sfc_s1;
	logic signed [ftc_pkg::FRAME_INDEX_BITS:0] diff_s1;
	ftc_pkg::item_t                           item_s2;

	logic [ftc_pkg::FRAME_INDEX_BITS-1:0]     ref_idx;
	logic [ftc_pkg::SSEC_W-1:0]               ssec;
	logic [ftc_pkg::FPS_W-1:0]                fps_eff;
	logic [ftc_pkg::PROD_W-1:0]               prod;
	logic signed [ftc_pkg::SUM_W-1:0]         total;
	ftc_pkg::item_t                           item_d;

	assign adv2     = !v_s2 || !q_full;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;
	assign q_push   = v_s2 && !q_full;
	assign q_item   = item_s2;

	assign ref_idx = ftc_pkg::FRAME_INDEX_BITS'(cfg.reference_index);
	assign ssec    = ftc_pkg::SSEC_W'(cfg.start_hours) * ftc_pkg::SEC_PER_HOUR
	               + ftc_pkg::SSEC_W'(cfg.start_minutes) * ftc_pkg::SEC_PER_MIN
	               + ftc_pkg::SSEC_W'(cfg.start_seconds);
	assign fps_eff = (cfg.frames_per_second == '0) ? ftc_pkg::FPS_W'(1) : cfg.frames_per_second;

	assign prod  = ftc_pkg::PROD_W'(ssec_s1) * ftc_pkg::PROD_W'(fps_s1);
	assign total = $signed(ftc_pkg::SUM_W'(prod)) + $signed(ftc_pkg::SUM_W'(sfc_s1))
	             + ftc_pkg::SUM_W'(diff_s1);

	always_comb begin
		item_d.unf = total[ftc_pkg::SUM_W-1];
		if (total[ftc_pkg::SUM_W-1]) begin
			item_d.tot = '0;
			item_d.fps = ftc_pkg::FPS_W'(1);
		end else begin
			item_d.tot = total[ftc_pkg::Q_W-1:0];
			item_d.fps = fps_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1)
				v_s1 <= in_valid;
			if (adv2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			ssec_s1 <= ssec;
			fps_s1  <= fps_eff;
			sfc_s1  <= cfg.start_frame_count;
			diff_s1 <= $signed({1'b0, frame_index}) - $signed({1'b0, ref_idx});
		end
		if (adv2)
			item_s2 <= item_d;
	end

endmodule

@@ hdl/ftc_queue.sv @@
module ftc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ftc_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           head_vld,
	output ftc_pkg::item_t head
);

	ftc_pkg::item_t              mem_q [ftc_pkg::QUEUE_DEPTH];
	logic [ftc_pkg::QPTR_W-1:0]  wr_q;
	logic [ftc_pkg::QPTR_W-1:0]  rd_q;
	logic [ftc_pkg::QPTR_W:0]    cnt_q;

	assign full     = (cnt_q == (ftc_pkg::QPTR_W + 1)'(ftc_pkg::QUEUE_DEPTH));
	assign head_vld = (cnt_q != '0);
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

endmodule

@@ hdl/ftc_back.sv @@
module ftc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_vld,
	input  ftc_pkg::item_t                head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ftc_pkg::HOURS_W-1:0]   hours,
	output logic [ftc_pkg::MS_W-1:0]      minutes,
	output logic [ftc_pkg::MS_W-1:0]      seconds,
	output logic [ftc_pkg::FRM_W-1:0]     frame_field,
	output logic                          underflow
);

	localparam int N = ftc_pkg::Q_W;

	ftc_pkg::fdiv_t fd_q [N];
	logic [N-1:0]   fv_q;

	logic                        v_s1;
	logic [ftc_pkg::HQ_W-1:0]    hrs_s1;
	logic [ftc_pkg::REM_W-1:0]   lo_s1;
	logic [ftc_pkg::FRM_W-1:0]   frm_s1;
	logic                        unf_s1;

	logic                        v_s2;
	logic [ftc_pkg::HOURS_W-1:0] hrs_s2;
	logic [ftc_pkg::REM_W-1:0]   rem_s2;
	logic [ftc_pkg::FRM_W-1:0]   frm_s2;
	logic                        unf_s2;

	logic                        v_s3;
	logic [ftc_pkg::HOURS_W-1:0] hrs_s3;
	logic [ftc_pkg::MS_W-1:0]    min_s3;
	logic [ftc_pkg::MS_W-1:0]    rlo_s3;
	logic [ftc_pkg::FRM_W-1:0]   frm_s3;
	logic                        unf_s3;

	logic                        out_vld_q;
	logic [ftc_pkg::HOURS_W-1:0] hours_q;
	logic [ftc_pkg::MS_W-1:0]    minutes_q;
	logic [ftc_pkg::MS_W-1:0]    seconds_q;
	logic [ftc_pkg::FRM_W-1:0]   frm_q;
	logic                        unf_q;

	logic                        adv;
	ftc_pkg::fdiv_t              fd_in;
	ftc_pkg::fdiv_t              fd_last;
	logic [ftc_pkg::HQ_W-1:0]    hrs_d;
	logic [ftc_pkg::HOURS_W-1:0] hrs_sat;
	logic [ftc_pkg::MS_W-1:0]    min_d;

	assign adv = !out_vld_q || out_ready;
	assign pop = adv && head_vld;

	assign fd_in.num = head.tot;
	assign fd_in.rem = '0;
	assign fd_in.fps = head.fps;
	assign fd_in.unf = head.unf;

	assign fd_last = fd_q[N-1];

	// seconds / 3600 and remainder / 60 by reciprocal multiply
	assign hrs_d = ftc_pkg::HQ_W'((ftc_pkg::HPROD_W'(fd_last.num)
	             * ftc_pkg::HPROD_W'(ftc_pkg::DIVH_M)) >> ftc_pkg::DIVH_K);
	assign hrs_sat = (hrs_s1 > ftc_pkg::HQ_W'(ftc_pkg::HOURS_MAX)) ? ftc_pkg::HOURS_MAX
	                                                               : ftc_pkg::HOURS_W'(hrs_s1);
	assign min_d = ftc_pkg::MS_W'((ftc_pkg::MPROD_W'(rem_s2)
	             * ftc_pkg::MPROD_W'(ftc_pkg::DIVM_M)) >> ftc_pkg::DIVM_K);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q      <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			fv_q      <= {fv_q[N-2:0], head_vld};
			v_s1      <= fv_q[N-1];
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_vld_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fd_q[0] <= ftc_pkg::fdiv_step(fd_in);
			for (int i = 1; i < N; i++)
				fd_q[i] <= ftc_pkg::fdiv_step(fd_q[i-1]);
			hrs_s1    <= hrs_d;
			lo_s1     <= fd_last.num[ftc_pkg::REM_W-1:0];
			frm_s1    <= fd_last.rem;
			unf_s1    <= fd_last.unf;
			hrs_s2    <= hrs_sat;
			rem_s2    <= lo_s1 - ftc_pkg::REM_W'(hrs_s1[ftc_pkg::REM_W-1:0] * ftc_pkg::HOUR_LO);
			frm_s2    <= frm_s1;
			unf_s2    <= unf_s1;
			hrs_s3    <= hrs_s2;
			min_s3    <= min_d;
			rlo_s3    <= rem_s2[ftc_pkg::MS_W-1:0];
			frm_s3    <= frm_s2;
			unf_s3    <= unf_s2;
			hours_q   <= hrs_s3;
			minutes_q <= min_s3;
			seconds_q <= rlo_s3 - ftc_pkg::MS_W'(min_s3 * ftc_pkg::MIN_LO);
			frm_q     <= frm_s3;
			unf_q     <= unf_s3;
		end
	end

	assign out_valid   = out_vld_q;
	assign hours       = hours_q;
	assign minutes     = minutes_q;
	assign seconds     = seconds_q;
	assign frame_field = frm_q;
	assign underflow   = unf_q;

	a_rate_rem: assert property (@(posedge clk) disable iff (!arst_n)
		fv_q[N-1] |-> (fd_q[N-1].rem < fd_q[N-1].fps))
		else $error("frame remainder not below rate");

	a_unf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && unf_q) |-> (hours_q == '0 && minutes_q == '0 &&
		                          seconds_q == '0 && frm_q == '0))
		else $error("underflow word with nonzero timecode");

	a_base60: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (minutes_q < ftc_pkg::MS_W'(60) && seconds_q < ftc_pkg::MS_W'(60)))
		else $error("minutes or seconds out of range");

endmodule

@@ hdl/frame_to_timecode.sv @@
// Frame index to non-drop-frame timecode.
//
// cfg_valid/cfg_ready/cfg_index/cfg_data write the start timecode, the
// reference frame index and the frame rate; cfg_ready is always high and
// indexes above 5 are dropped. Write only while no word is in flight.
// A rate of 0 counts as 1.
// in_valid/in_ready carry one frame_index per word; out_valid/out_ready
// carry one timecode word per input word, in order.
// Throughput: one word per cycle while out_ready stays high. Pipeline: two
// front stages, the queue, Q_W bit-serial steps dividing by the rate, three
// stages splitting seconds into hours, minutes and seconds by reciprocal
// multiplies, then the output register.
// A four-word queue sits between the front (total and sign) and the back
// (dividers); a stalled receiver freezes the back, the queue fills, and
// then in_ready drops. The output register holds a word until taken.
// Reset clears all valid state and loads rate 24 with a zero start timecode.
// A negative frame total returns underflow with all other fields zero.
module frame_to_timecode (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ftc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ftc_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ftc_pkg::FRAME_INDEX_BITS-1:0] frame_index,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [ftc_pkg::HOURS_W-1:0]          hours,
	output logic [ftc_pkg::MS_W-1:0]             minutes,
	output logic [ftc_pkg::MS_W-1:0]             seconds,
	output logic [ftc_pkg::FRM_W-1:0]            frame_field,
	output logic                                 underflow
);

	ftc_pkg::cfg_t  cfg_q;
	logic           q_full;
	logic           q_push;
	ftc_pkg::item_t q_item;
	logic           q_pop;
	logic           q_vld;
	ftc_pkg::item_t q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_hours       <= '0;
			cfg_q.start_minutes     <= '0;
			cfg_q.start_seconds     <= '0;
			cfg_q.start_frame_count <= '0;
			cfg_q.reference_index   <= '0;
			cfg_q.frames_per_second <= ftc_pkg::FPS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				ftc_pkg::REG_START_HOURS: begin
					cfg_q.start_hours <= cfg_data[ftc_pkg::HRS_CFG_W-1:0];
				end
				ftc_pkg::REG_START_MINUTES: begin
					cfg_q.start_minutes <= cfg_data[ftc_pkg::MS_W-1:0];
				end
				ftc_pkg::REG_START_SECONDS: begin
					cfg_q.start_seconds <= cfg_data[ftc_pkg::MS_W-1:0];
				end
				ftc_pkg::REG_START_FRAMES: begin
					cfg_q.start_frame_count <= cfg_data[ftc_pkg::FRM_W-1:0];
				end
				ftc_pkg::REG_REFERENCE: begin
					cfg_q.reference_index <= cfg_data[ftc_pkg::REF_W-1:0];
				end
				ftc_pkg::REG_FPS: begin
					cfg_q.frames_per_second <= cfg_data[ftc_pkg::FPS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	ftc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.frame_index (frame_index),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (q_item)
	);

	ftc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.head_vld  (q_vld),
		.head      (q_head)
	);

	ftc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_vld    (q_vld),
		.head        (q_head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hours       (hours),
		.minutes     (minutes),
		.seconds     (seconds),
		.frame_field (frame_field),
		.underflow   (underflow)
	);

endmodule
